// ===== rtl/local_max_3x3_suppression_core_assert.svh =====
// Assertion macros of the checker of the 3x3 local-maximum core.
`ifndef LOCAL_MAX_3X3_SUPPRESSION_CORE_ASSERT_SVH
`define LOCAL_MAX_3X3_SUPPRESSION_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define LMX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LMX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lmx_pkg.sv =====
// Shared types and constants of the 3x3 local-maximum core.
package lmx_pkg;

  // Fixed field widths
  localparam int ROW_W      = 16;
  localparam int COL_OUT_W  = 10;
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 16;
  localparam int TOL_CFG_W  = 16;
  localparam int SHIFT_W    = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 2;

  // Register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_ABS_TOL   = 2'd2,
    REG_REL_SHIFT = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [WCFG_W-1:0]    WIDTH_RST     = 11'd1024;
  localparam logic [HCFG_W-1:0]    HEIGHT_RST    = 16'd1024;
  localparam logic [TOL_CFG_W-1:0] ABS_TOL_RST   = 16'd0;
  localparam logic [SHIFT_W-1:0]   REL_SHIFT_RST = 5'd17;

  // Pixels decided per input sample: up-left, up, left, self
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_UL   = 0;  // (row-1, col-1)
  localparam int SLOT_UR   = 1;  // (row-1, col), last column only
  localparam int SLOT_LL   = 2;  // (row, col-1), last row only
  localparam int SLOT_LR   = 3;  // (row, col), last pixel of the frame

  // Position flags of one sample, carried down the pipeline
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
  } pos_t;

endpackage

// ===== rtl/lmx_line_buf.sv =====
// Line store: both previous rows of one column in one word, one read and one write port.
module lmx_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lmx_judge.sv =====
// 3x3 window registers, neighborhood maxima and the tolerance test.
module lmx_judge import lmx_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int ADDR_W      = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  // window load (stage C)
  input  logic                          load_c,
  input  logic signed [SAMPLE_BITS-1:0] rd_older,
  input  logic signed [SAMPLE_BITS-1:0] rd_newer,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  pos_t                          pos_in,
  input  logic [ROW_W-1:0]              row_in,
  input  logic [ADDR_W-1:0]             col_in,
  // maxima load (stage D)
  input  logic                          load_d,
  input  logic [TOL_CFG_W-1:0]          abs_tol,
  input  logic [SHIFT_W-1:0]            rel_shift,
  // stage D results
  output logic [NUM_SLOTS-1:0]          pass,
  output logic signed [SAMPLE_BITS-1:0] peak [NUM_SLOTS],
  output logic [ROW_W-1:0]              row_d,
  output logic [ADDR_W-1:0]             col_d
);

  localparam int SB    = SAMPLE_BITS;
  localparam int TOL_W = ((SB > TOL_CFG_W) ? SB : TOL_CFG_W) + 1;
  localparam logic signed [SB-1:0] NEG_SAMPLE = {1'b1, {(SB-1){1'b0}}};

  // window, index row*3+col; row 2 / col 2 is the newest
  logic signed [SB-1:0] win [9];
  pos_t                 pos_c;
  logic [ROW_W-1:0]     row_c;
  logic [ADDR_W-1:0]    col_c;

  logic signed [SB-1:0]  mx_c   [NUM_SLOTS];
  logic signed [SB-1:0]  ctr_c  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  judge_c;
  logic signed [SB-1:0]  ctr_d  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  judge_d;

  function automatic logic signed [SB-1:0] smax(input logic signed [SB-1:0] a,
                                                input logic signed [SB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // inclusion mask from row and column masks
  function automatic logic [8:0] inc_of(input logic [2:0] rm, input logic [2:0] cm);
    logic [8:0] inc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        inc[i*3+j] = rm[i] & cm[j];
      end
    end
    return inc;
  endfunction

  // max over the included window entries, a four-level tree
  function automatic logic signed [SB-1:0] nb_max(input logic signed [SB-1:0] v [9],
                                                  input logic [8:0] inc);
    logic signed [SB-1:0] m [9];
    logic signed [SB-1:0] t [4];
    logic signed [SB-1:0] u0;
    logic signed [SB-1:0] u1;
    for (int k = 0; k < 9; k++) begin
      m[k] = inc[k] ? v[k] : NEG_SAMPLE;
    end
    t[0] = smax(m[0], m[1]);
    t[1] = smax(m[2], m[3]);
    t[2] = smax(m[4], m[5]);
    t[3] = smax(m[6], m[7]);
    u0   = smax(t[0], t[1]);
    u1   = smax(t[2], t[3]);
    return smax(smax(u0, u1), m[8]);
  endfunction

  // stage C: shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (load_c) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]   <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= rd_older;
      win[5] <= rd_newer;
      win[8] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      pos_c <= pos_in;
      row_c <= row_in;
      col_c <= col_in;
    end
  end

  // clipped neighborhoods of the four candidate pixels
  always_comb begin
    logic       row0_ok;
    logic       col0_ok;
    row0_ok = pos_c.r_ge2;
    col0_ok = pos_c.c_ge2;

    mx_c[SLOT_UL]  = nb_max(win, inc_of({2'b11, row0_ok}, {2'b11, col0_ok}));
    mx_c[SLOT_UR]  = nb_max(win, inc_of({2'b11, row0_ok}, 3'b110));
    mx_c[SLOT_LL]  = nb_max(win, inc_of(3'b110, {2'b11, col0_ok}));
    mx_c[SLOT_LR]  = nb_max(win, inc_of(3'b110, 3'b110));

    ctr_c[SLOT_UL] = win[4];
    ctr_c[SLOT_UR] = win[5];
    ctr_c[SLOT_LL] = win[7];
    ctr_c[SLOT_LR] = win[8];

    judge_c[SLOT_UL] = pos_c.r_ge1 & pos_c.c_ge1;
    judge_c[SLOT_UR] = pos_c.r_ge1 & pos_c.last_col;
    judge_c[SLOT_LL] = pos_c.last_row & pos_c.c_ge1;
    judge_c[SLOT_LR] = pos_c.last_row & pos_c.last_col;
  end

  // stage D registers
  always_ff @(posedge clk) begin
    if (load_d) begin
      peak    <= mx_c;
      ctr_d   <= ctr_c;
      judge_d <= judge_c;
      row_d   <= row_c;
      col_d   <= col_c;
    end
  end

  // positive peak and (peak - centre) <= abs_tol + (peak >> rel_shift)
  always_comb begin
    logic [SB-1:0]    diff;
    logic [TOL_W-1:0] tol;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      diff    = peak[k] - ctr_d[k];
      tol     = TOL_W'(abs_tol) + TOL_W'(peak[k] >>> rel_shift);
      pass[k] = judge_d[k] && (peak[k] > 0) && (TOL_W'(diff) <= tol);
    end
  end

endmodule

// ===== rtl/lmx_out_buf.sv =====
// Result buffer: holds the passing pixels of one sample and sends them in order.
module lmx_out_buf import lmx_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int ADDR_W      = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [NUM_SLOTS-1:0]          pass,
  input  logic signed [SAMPLE_BITS-1:0] peak_in [NUM_SLOTS],
  input  logic [ROW_W-1:0]              row_in,
  input  logic [ADDR_W-1:0]             col_in,
  output logic                          buf_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ROW_W-1:0]              row_out,
  output logic [COL_OUT_W-1:0]          col_out,
  output logic signed [SAMPLE_BITS-1:0] peak_out,
  output logic                          last_out
);

  logic [NUM_SLOTS-1:0]          pend;
  logic [ROW_W-1:0]              row_q  [NUM_SLOTS];
  logic [COL_OUT_W-1:0]          col_q  [NUM_SLOTS];
  logic signed [SAMPLE_BITS-1:0] peak_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]          low;
  logic [NUM_SLOTS-1:0]          rest;
  logic [ROW_W-1:0]              row_up;
  logic [COL_OUT_W-1:0]          col_here;
  logic [COL_OUT_W-1:0]          col_left;

  // oldest pending result is the lowest slot
  assign low       = pend & (~pend + NUM_SLOTS'(1));
  assign rest      = pend & ~low;
  assign out_valid = |pend;
  assign last_out  = (rest == '0);
  assign buf_free  = (pend == '0) | (out_ready & (rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= pass;
    end else if (out_valid && out_ready) begin
      pend <= rest;
    end
  end

  // pixel coordinates of each slot
  assign row_up   = row_in - ROW_W'(1);
  assign col_here = COL_OUT_W'(col_in);
  assign col_left = COL_OUT_W'(col_in - ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (load) begin
      row_q[SLOT_UL] <= row_up;
      row_q[SLOT_UR] <= row_up;
      row_q[SLOT_LL] <= row_in;
      row_q[SLOT_LR] <= row_in;
      col_q[SLOT_UL] <= col_left;
      col_q[SLOT_UR] <= col_here;
      col_q[SLOT_LL] <= col_left;
      col_q[SLOT_LR] <= col_here;
      peak_q         <= peak_in;
    end
  end

  // one-hot output select
  always_comb begin
    row_out  = '0;
    col_out  = '0;
    peak_out = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (low[k]) begin
        row_out  = row_out | row_q[k];
        col_out  = col_out | col_q[k];
        peak_out = peak_out | peak_q[k];
      end
    end
  end

endmodule

// ===== rtl/local_max_3x3_suppression_core.sv =====
// Top level of the 3x3 local-maximum core. Samples of a signed response map enter
// in raster order on the s_ stream and a pixel is reported on the m_ stream when the
// maximum of its border-clipped 3x3 neighborhood is positive and that maximum minus
// the pixel is at most abs_tol plus the maximum shifted right by rel_shift; all
// members of a plateau are reported. The block takes one sample per clock unless
// stalled. A pixel is decided once its neighborhood is complete; a sample decides at
// most four pixels (more than one only on the last column or row) and its results
// leave one per clock while m_tready is high, the last flagged by m_tlast. A sample
// with several results holds the input until its last is leaving, as the four-slot
// result buffer takes a new set only as the old one leaves. Writing the width or
// height register restarts the frame at row 0, column 0; write registers only while
// the block is idle. Width and height below 2 act as 2, width above MAX_WIDTH as
// MAX_WIDTH. The line store has no reset; border clipping hides unwritten entries.
module local_max_3x3_suppression_core import lmx_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // sample stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample
  // result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [((ROW_W+COL_OUT_W+SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // row, col, peak
  output logic                    m_tlast   // last result of a sample
);

  localparam int SB     = SAMPLE_BITS;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int OUT_W  = ((ROW_W + COL_OUT_W + SAMPLE_BITS + 7) / 8) * 8;

  // configuration registers
  logic [WCFG_W-1:0]    width_cfg;
  logic [HCFG_W-1:0]    height_cfg;
  logic [TOL_CFG_W-1:0] abs_tol;
  logic [SHIFT_W-1:0]   rel_shift;
  logic                 geom_wr;

  // frame position
  logic [ADDR_W-1:0] col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [ADDR_W-1:0] col_last;
  logic [ROW_W-1:0]  row_last;
  logic              at_last_col;
  logic              at_last_row;
  logic              accept;

  // pipeline control
  logic v_a, v_b, v_c, v_d;
  logic adv_a, adv_b, adv_c, adv_d;
  logic buf_free;

  // stage A / B payload
  pos_t                 pos_a, pos_b;
  logic [ROW_W-1:0]     row_a, row_b;
  logic [ADDR_W-1:0]    col_a, col_b;
  logic signed [SB-1:0] sample_a, sample_b;
  logic [2*SB-1:0]      rd_data;

  // stage D results
  logic [NUM_SLOTS-1:0] pass;
  logic signed [SB-1:0] peak_d [NUM_SLOTS];
  logic [ROW_W-1:0]     row_d;
  logic [ADDR_W-1:0]    col_d;

  // output fields
  logic [ROW_W-1:0]     row_out;
  logic [COL_OUT_W-1:0] col_out;
  logic signed [SB-1:0] peak_out;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= WIDTH_RST;
      height_cfg <= HEIGHT_RST;
      abs_tol    <= ABS_TOL_RST;
      rel_shift  <= REL_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_WIDTH:     width_cfg  <= cfg_wdata[WCFG_W-1:0];
        REG_HEIGHT:    height_cfg <= cfg_wdata[HCFG_W-1:0];
        REG_ABS_TOL:   abs_tol    <= cfg_wdata[TOL_CFG_W-1:0];
        REG_REL_SHIFT: rel_shift  <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom_wr = cfg_we && ((cfg_reg_t'(cfg_addr) == REG_WIDTH) ||
                              (cfg_reg_t'(cfg_addr) == REG_HEIGHT));

  // clamped geometry
  assign col_last = (width_cfg < WCFG_W'(2)) ? ADDR_W'(1) :
                    (32'(width_cfg) > 32'(MAX_WIDTH)) ? ADDR_W'(MAX_WIDTH - 1) :
                    ADDR_W'(width_cfg - WCFG_W'(1));
  assign row_last = (height_cfg < HCFG_W'(2)) ? ROW_W'(1) : (height_cfg - HCFG_W'(1));

  assign at_last_col = (col_cnt == col_last);
  assign at_last_row = (row_cnt == row_last);

  // pipeline advance, back to front
  assign adv_d    = !v_d || buf_free;
  assign adv_c    = !v_c || adv_d;
  assign adv_b    = !v_b || adv_c;
  assign adv_a    = !v_a || adv_b;
  assign s_tready = adv_a && !rst;
  assign accept   = s_tvalid && s_tready;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_cnt <= '0;
        row_cnt <= at_last_row ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + ADDR_W'(1);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      if (adv_a) v_a <= accept;
      if (adv_b) v_b <= v_a;
      if (adv_c) v_c <= v_b;
      if (adv_d) v_d <= v_c;
    end
  end

  // stage A: request with its position
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_a       <= s_tdata[SB-1:0];
      row_a          <= row_cnt;
      col_a          <= col_cnt;
      pos_a.r_ge1    <= (row_cnt != '0);
      pos_a.r_ge2    <= (row_cnt > ROW_W'(1));
      pos_a.c_ge1    <= (col_cnt != '0);
      pos_a.c_ge2    <= (col_cnt > ADDR_W'(1));
      pos_a.last_col <= at_last_col;
      pos_a.last_row <= at_last_row;
    end
  end

  // stage B: line store read lands here
  always_ff @(posedge clk) begin
    if (adv_b && v_a) begin
      sample_b <= sample_a;
      row_b    <= row_a;
      col_b    <= col_a;
      pos_b    <= pos_a;
    end
  end

  // word layout: older row high, newer row low
  lmx_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * SB)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (adv_b && v_a),
    .rd_addr (col_a),
    .rd_data (rd_data),
    .wr_en   (adv_c && v_b),
    .wr_addr (col_b),
    .wr_data ({rd_data[SB-1:0], sample_b})
  );

  lmx_judge #(
    .SAMPLE_BITS (SB),
    .ADDR_W      (ADDR_W)
  ) u_judge (
    .clk       (clk),
    .rst       (rst),
    .load_c    (adv_c && v_b),
    .rd_older  (rd_data[2*SB-1:SB]),
    .rd_newer  (rd_data[SB-1:0]),
    .sample_in (sample_b),
    .pos_in    (pos_b),
    .row_in    (row_b),
    .col_in    (col_b),
    .load_d    (adv_d && v_c),
    .abs_tol   (abs_tol),
    .rel_shift (rel_shift),
    .pass      (pass),
    .peak      (peak_d),
    .row_d     (row_d),
    .col_d     (col_d)
  );

  lmx_out_buf #(
    .SAMPLE_BITS (SB),
    .ADDR_W      (ADDR_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (v_d && buf_free),
    .pass      (pass),
    .peak_in   (peak_d),
    .row_in    (row_d),
    .col_in    (col_d),
    .buf_free  (buf_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .row_out   (row_out),
    .col_out   (col_out),
    .peak_out  (peak_out),
    .last_out  (m_tlast)
  );

  assign m_tdata = OUT_W'({peak_out, col_out, row_out});

endmodule

// ===== rtl/lmx_assert_chk.sv =====
// Port-level checker of the 3x3 local-maximum core and its bind.
`include "local_max_3x3_suppression_core_assert.svh"

module lmx_assert_chk #(
  parameter int OUT_W = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // a stalled result keeps its value
  `LMX_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // reset empties the result buffer
  `LMX_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // a burst without its last flag continues in the next cycle
  `LMX_ASSERT(a_burst_cont, clk, rst, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "burst ended without last")

  // an empty result buffer never blocks the input
  `LMX_ASSERT(a_ready_idle, clk, rst, !m_tvalid |-> s_tready, "input stalled with no result pending")

endmodule

bind local_max_3x3_suppression_core lmx_assert_chk #(
  .OUT_W (OUT_W)
) u_lmx_assert_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
